[sv/pra_pkg.sv]
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants for plane_rotation_accumulate
// Holds the CORDIC table, turn constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package pra_pkg;

  localparam int unsigned AngW = 32;
  localparam int unsigned WrapW = 25;
  localparam int unsigned DataW = 32;
  localparam int unsigned CordicSteps = 22;
  localparam int unsigned StepW = 5;

  localparam logic signed [33:0] FullTurn = 34'sd23592960;
  localparam logic signed [33:0] HalfTurn = 34'sd11796480;
  localparam logic signed [33:0] QuarterTurn = 34'sd5898240;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  // Wrap search: the remainder is found by subtracting shifted copies of a turn.
  localparam int unsigned WrapSteps = 9;
  // A negative angle is lifted by 128 turns, which exceeds any 32-bit magnitude.
  localparam int unsigned LiftShift = 7;

  function automatic logic signed [33:0] atan_q16(input logic [StepW-1:0] idx);
    logic signed [33:0] r;
    begin
      case (idx)
        5'd0: r = 34'sd2949120;
        5'd1: r = 34'sd1740967;
        5'd2: r = 34'sd919879;
        5'd3: r = 34'sd466945;
        5'd4: r = 34'sd234379;
        5'd5: r = 34'sd117304;
        5'd6: r = 34'sd58666;
        5'd7: r = 34'sd29335;
        5'd8: r = 34'sd14668;
        5'd9: r = 34'sd7334;
        5'd10: r = 34'sd3667;
        5'd11: r = 34'sd1833;
        5'd12: r = 34'sd917;
        5'd13: r = 34'sd458;
        5'd14: r = 34'sd229;
        5'd15: r = 34'sd115;
        5'd16: r = 34'sd57;
        5'd17: r = 34'sd29;
        5'd18: r = 34'sd14;
        5'd19: r = 34'sd7;
        5'd20: r = 34'sd4;
        5'd21: r = 34'sd2;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

  typedef enum logic [2:0] {
    CmdIdle,
    CmdLoad,
    CmdWrap,
    CmdCordicInit,
    CmdCordicStep,
    CmdCordicDone,
    CmdMac,
    CmdMacStore
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e        op;
    logic           sel_spin;   // CORDIC works on spin when set, tilt otherwise
    logic [3:0]     wrap_idx;
    logic [StepW-1:0] step;
    logic           pass2;      // second product of incremental mode
    logic [1:0]     row;
    logic [1:0]     col;
    logic [1:0]     k;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
  } dp_stat_t;

endpackage

[sv/pra_datapath.sv]
// ----------------------------------------------------------------------------
// pra_datapath: angle wrap, shared CORDIC and shared multiply-accumulate
// Executes one command per cycle as issued by the controller.
// ----------------------------------------------------------------------------
module pra_datapath import pra_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic                    in_mode_i,
  input  logic signed [AngW-1:0]  in_tilt_i,
  input  logic signed [AngW-1:0]  in_spin_i,
  output dp_stat_t                stat_o,
  output logic [3*DataW-1:0]      normal_o,
  output logic [WrapW-1:0]        wrap_tilt_o,
  output logic [WrapW-1:0]        wrap_spin_o
);

  logic signed [DataW-1:0] mat_q [9];
  logic signed [DataW-1:0] mat_d [9];
  logic signed [DataW-1:0] tmp_q [9];
  logic signed [DataW-1:0] tmp_d [9];
  logic signed [33:0] tilt_q, tilt_d, spin_q, spin_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, ca_q, ca_d;
  logic flip_q, flip_d;
  logic signed [DataW-1:0] sx_q, sx_d, cxo_q, cxo_d, sy_q, sy_d, cyo_q, cyo_d;
  logic signed [65:0] acc_q, acc_d;
  logic mode_q, mode_d;

  logic signed [33:0] a0, a1, xf, yf, dx, dy, wr, sub, xo, yo;
  logic signed [DataW-1:0] opa, opb, cl_s, cl_c;
  logic signed [63:0] prod;
  logic signed [65:0] sum, rnd;
  logic signed [DataW-1:0] sat;
  logic [3:0] ai, bi;

  function automatic logic signed [DataW-1:0] clampu(input logic signed [33:0] v);
    logic signed [33:0] one;
    begin
      one = 34'sd1073741824;
      if (v > one) return OneQ30;
      else if (v < -one) return -OneQ30;
      else return v[DataW-1:0];
    end
  endfunction

  // Element of Rx (first operand in incremental pass 1, second operand in absolute mode) or Ry.
  function automatic logic signed [DataW-1:0] rot_el(input logic is_y, input logic [3:0] idx,
      input logic signed [DataW-1:0] s, input logic signed [DataW-1:0] c);
    logic signed [DataW-1:0] r;
    begin
      r = '0;
      if (!is_y) begin
        case (idx)
          4'd0: r = OneQ30;
          4'd4, 4'd8: r = c;
          4'd5: r = -s;
          4'd7: r = s;
          default: r = '0;
        endcase
      end else begin
        case (idx)
          4'd0, 4'd8: r = c;
          4'd2: r = s;
          4'd4: r = OneQ30;
          4'd6: r = -s;
          default: r = '0;
        endcase
      end
      return r;
    end
  endfunction

  always_comb begin
    ai = 4'({2'd0, cmd_i.row} * 4'd3 + {2'd0, cmd_i.k});
    bi = 4'({2'd0, cmd_i.k} * 4'd3 + {2'd0, cmd_i.col});
    // Absolute: Ry*Rx. Incremental: pass 1 Rx*M, pass 2 Ry*T.
    if (mode_q) begin
      opa = rot_el(1'b1, ai, sy_q, cyo_q);
      opb = rot_el(1'b0, bi, sx_q, cxo_q);
    end else if (!cmd_i.pass2) begin
      opa = rot_el(1'b0, ai, sx_q, cxo_q);
      opb = mat_q[bi];
    end else begin
      opa = rot_el(1'b1, ai, sy_q, cyo_q);
      opb = tmp_q[bi];
    end
    prod = 64'(opa) * 64'(opb);
    sum = acc_q + 66'(prod);
    rnd = (acc_q + 66'sd536870912) >>> 30;
    if (rnd > 66'sd2147483647) sat = 32'sh7fffffff;
    else if (rnd < -66'sd2147483648) sat = 32'sh80000000;
    else sat = rnd[DataW-1:0];

    wr = cmd_i.sel_spin ? spin_q : tilt_q;
    sub = wr - (FullTurn <<< cmd_i.wrap_idx);
    a0 = (wr >= HalfTurn) ? wr - FullTurn : wr;
    if (a0 > QuarterTurn) a1 = a0 - HalfTurn;
    else if (a0 < -QuarterTurn) a1 = a0 + HalfTurn;
    else a1 = a0;
    xf = cx_q;
    yf = cy_q;
    dx = yf >>> cmd_i.step;
    dy = xf >>> cmd_i.step;
    xo = flip_q ? -cx_q : cx_q;
    yo = flip_q ? -cy_q : cy_q;
    cl_s = clampu(yo);
    cl_c = clampu(xo);
  end

  always_comb begin
    mat_d = mat_q; tmp_d = tmp_q;
    tilt_d = tilt_q; spin_d = spin_q;
    cx_d = cx_q; cy_d = cy_q; ca_d = ca_q; flip_d = flip_q;
    sx_d = sx_q; cxo_d = cxo_q; sy_d = sy_q; cyo_d = cyo_q;
    acc_d = acc_q; mode_d = mode_q;
    case (cmd_i.op)
      CmdLoad: begin
        mode_d = in_mode_i;
        tilt_d = 34'(in_tilt_i);
        spin_d = 34'(in_spin_i);
      end
      CmdWrap: begin
        // Restoring reduction: first lift negatives, then strip multiples.
        if (cmd_i.wrap_idx == 4'(WrapSteps)) begin
          if (wr < 0) begin
            if (cmd_i.sel_spin) spin_d = wr + (FullTurn <<< LiftShift);
            else tilt_d = wr + (FullTurn <<< LiftShift);
          end
        end else if (sub >= 0) begin
          if (cmd_i.sel_spin) spin_d = sub;
          else tilt_d = sub;
        end
      end
      CmdCordicInit: begin
        cx_d = CordicGain;
        cy_d = '0;
        ca_d = a1;
        flip_d = (a0 > QuarterTurn) || (a0 < -QuarterTurn);
      end
      CmdCordicStep: begin
        if (ca_q >= 0) begin
          cx_d = cx_q - dx; cy_d = cy_q + dy; ca_d = ca_q - atan_q16(cmd_i.step);
        end else begin
          cx_d = cx_q + dx; cy_d = cy_q - dy; ca_d = ca_q + atan_q16(cmd_i.step);
        end
      end
      CmdCordicDone: begin
        if (cmd_i.sel_spin) begin sy_d = cl_s; cyo_d = cl_c; end
        else begin sx_d = cl_s; cxo_d = cl_c; end
        acc_d = '0;
      end
      CmdMac: acc_d = sum;
      CmdMacStore: begin
        if (!mode_q && !cmd_i.pass2) tmp_d[4'({2'd0, cmd_i.row} * 4'd3 + {2'd0, cmd_i.col})] = sat;
        else mat_d[4'({2'd0, cmd_i.row} * 4'd3 + {2'd0, cmd_i.col})] = sat;
        acc_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) mat_q[i] <= (i % 4 == 0) ? OneQ30 : '0;
    end else begin
      mat_q <= mat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d; tilt_q <= tilt_d; spin_q <= spin_d;
    cx_q <= cx_d; cy_q <= cy_d; ca_q <= ca_d; flip_q <= flip_d;
    sx_q <= sx_d; cxo_q <= cxo_d; sy_q <= sy_d; cyo_q <= cyo_d;
    acc_q <= acc_d; mode_q <= mode_d;
  end

  assign stat_o.mode = mode_q;
  assign normal_o = {mat_q[8], mat_q[5], mat_q[2]};
  assign wrap_tilt_o = tilt_q[WrapW-1:0];
  assign wrap_spin_o = spin_q[WrapW-1:0];

endmodule

[sv/pra_ctrl.sv]
// ----------------------------------------------------------------------------
// pra_ctrl: sequencer for wrap, CORDIC and matrix product passes
// Issues one datapath command per cycle and runs the stream handshake.
// ----------------------------------------------------------------------------
module pra_ctrl import pra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StWrap, StCInit, StCStep, StCDone, StMac, StStore, StOut
  } state_e;

  state_e state_q;
  logic sel_q, pass2_q, out_valid_q;
  logic [3:0] widx_q;
  logic [StepW-1:0] step_q;
  logic [1:0] row_q, col_q, k_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.sel_spin = sel_q;
    cmd_o.wrap_idx = widx_q;
    cmd_o.step = step_q;
    cmd_o.pass2 = pass2_q;
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    cmd_o.k = k_q;
    case (state_q)
      StIdle:  cmd_o.op = (in_valid_i && !out_valid_q) ? CmdLoad : CmdIdle;
      StWrap:  cmd_o.op = CmdWrap;
      StCInit: cmd_o.op = CmdCordicInit;
      StCStep: cmd_o.op = CmdCordicStep;
      StCDone: cmd_o.op = CmdCordicDone;
      StMac:   cmd_o.op = CmdMac;
      StStore: cmd_o.op = CmdMacStore;
      default: cmd_o.op = CmdIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q <= 1'b0; pass2_q <= 1'b0; out_valid_q <= 1'b0;
      widx_q <= '0; step_q <= '0; row_q <= '0; col_q <= '0; k_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && !out_valid_q) begin
          state_q <= StWrap; sel_q <= 1'b0; widx_q <= 4'(WrapSteps);
        end
        StWrap: begin
          if (widx_q == '0) begin
            if (sel_q) begin
              sel_q <= 1'b0; state_q <= StCInit;
            end else begin
              sel_q <= 1'b1; widx_q <= 4'(WrapSteps);
            end
          end else widx_q <= widx_q - 4'd1;
        end
        StCInit: begin state_q <= StCStep; step_q <= '0; end
        StCStep: begin
          if (step_q == StepW'(CordicSteps - 1)) state_q <= StCDone;
          else step_q <= step_q + StepW'(1);
        end
        StCDone: begin
          if (sel_q) begin
            state_q <= StMac; pass2_q <= 1'b0;
            row_q <= '0; col_q <= '0; k_q <= '0;
          end else begin
            sel_q <= 1'b1; state_q <= StCInit;
          end
        end
        StMac: begin
          if (k_q == 2'd2) state_q <= StStore;
          else k_q <= k_q + 2'd1;
        end
        StStore: begin
          k_q <= '0;
          state_q <= StMac;
          if (col_q != 2'd2) col_q <= col_q + 2'd1;
          else begin
            col_q <= '0;
            if (row_q != 2'd2) row_q <= row_q + 2'd1;
            else begin
              row_q <= '0;
              if (!stat_i.mode && !pass2_q) pass2_q <= 1'b1;
              else begin
                state_q <= StOut; out_valid_q <= 1'b1;
              end
            end
          end
        end
        StOut: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q) else $error("result dropped");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCStep) |-> (step_q < StepW'(CordicSteps))) else $error("step range");
`endif

endmodule

[sv/plane_rotation_accumulate.sv]
// ----------------------------------------------------------------------------
// plane_rotation_accumulate: x-then-y rotation composed onto or replacing a stored matrix
// Wraps two angles, forms sine and cosine by CORDIC, updates a 3x3 rotation.
// ----------------------------------------------------------------------------
// The next input is taken in the cycle after the result transaction, so one item
// is finished and delivered before the next is accepted. The processing time is
// set by the serial wrap of both angles, the shared CORDIC run once per angle
// and the single multiply-accumulate unit, which forms the matrix entries in
// turn and makes a second product pass in incremental mode.
// Reset restores the stored rotation to the identity and empties the output.
module plane_rotation_accumulate import pra_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: tilt_angle[31:0], spin_angle[63:32]
  input  logic [63:0]  s_axis_tdata,
  // tuser: mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: normal_x[31:0], normal_y[63:32], normal_z[95:64],
  // wrapped_tilt[120:96], wrapped_spin[145:121], zero fill to 151
  output logic [151:0] m_axis_tdata
);

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [3*DataW-1:0] normal;
  logic [WrapW-1:0] wt, ws;

  // The controller sequences every transaction; the datapath holds all values.
  pra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  pra_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .in_mode_i(s_axis_tuser),
    .in_tilt_i(s_axis_tdata[31:0]),
    .in_spin_i(s_axis_tdata[63:32]),
    .stat_o(stat), .normal_o(normal),
    .wrap_tilt_o(wt), .wrap_spin_o(ws)
  );

  // The result stays in the datapath registers until it is taken.
  assign m_axis_tdata = {6'd0, ws, wt, normal};

endmodule
